[rtl/rac_pkg.sv]
// Package for the radix ASCII converter.
// Holds the widths, codes, state encoding and digit-to-ASCII function.
// No dependencies.
`timescale 1ns / 1ps

package rac_pkg;

   localparam int VALUE_BITS = 64;
   localparam int MAX_DIGITS = 64;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 7;
   localparam int STEP_BITS  = 8;
   localparam int STEPS      = VALUE_BITS / STEP_BITS;
   localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;
   localparam logic [RADIX_W-1:0] DEC_LAST    = 6'd9;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_LOW_A = 7'h61;

   // register index taken from paddr bit 2
   localparam logic REG_RADIX = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_RD   = 5'b00100,
      ST_LD   = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic               done;
      logic [RADIX_W-1:0] digit;
      logic               quot_zero;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d > DEC_LAST) begin
         c = CHAR_W'(d - DEC_DIGITS) + ASCII_LOW_A;
      end else begin
         c = CHAR_W'(d) + ASCII_ZERO;
      end
      return c;
   endfunction

endpackage

[rtl/rac_digit_div.sv]
// Digit divider: divides the value by the radix, eight bits a cycle.
// Leaves the quotient in place and the remainder as the digit.
// Depends on rac_pkg.
`timescale 1ns / 1ps

module rac_digit_div
   import rac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RADIX_W-1:0]    radix,
   input  logic [VALUE_BITS-1:0] value,
   output div_status_type        status,
   output logic [VALUE_BITS-1:0] quotient
);

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  qnz_ff, qnz_in;
   logic [STEP_BITS-1:0]  qbits;
   logic [RADIX_W-1:0]    rem_step;
   logic [RADIX_W:0]      trial;

   always_comb begin
      rem_step = rem_ff;
      qbits    = '0;
      trial    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {rem_step, shift_ff[VALUE_BITS-1-i]};
         if (trial >= {1'b0, radix}) begin
            trial = trial - {1'b0, radix};
            qbits[STEP_BITS-1-i] = 1'b1;
         end
         rem_step = trial[RADIX_W-1:0];
      end
   end

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      qnz_in   = qnz_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = value;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
         qnz_in   = 1'b0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_BITS-STEP_BITS-1:0], qbits};
         rem_in   = rem_step;
         cnt_in   = cnt_ff + 1'b1;
         qnz_in   = qnz_ff | (|qbits);
         if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         qnz_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         qnz_ff  <= qnz_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign status   = {done_ff, rem_ff, ~qnz_ff};
   assign quotient = shift_ff;

endmodule

[rtl/radix_ascii_converter.sv]
// Top level of the radix ASCII converter.
// Holds the control sequencer, digit memory, CSR port and output register.
// Depends on rac_pkg and rac_digit_div.
`timescale 1ns / 1ps

// Converts one unsigned 64-bit value per transfer into ASCII text in the
// radix held in register 0 (2 to 36; 0 and 1 read as 2, above 36 as 36),
// most significant digit first, last_digit set on the final character.
// One value is in flight at a time: req_stall stays high from acceptance
// until the last digit has been taken. For each digit the divider loads the
// dividend, then works through eight steps of eight bits each; afterwards
// each digit is read back from the digit memory (ST_RD), loaded into the
// output register (ST_LD) and shown (ST_OUT) until taken, so the time from
// one input transfer to the next grows with the number of digits and with
// rsp_stall; radix 2 with a full 64-bit value is the worst case.

module radix_ascii_converter
   import rac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_digit_char,
   output logic                  rsp_last_digit,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   state_type             state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff;
   logic [RADIX_W-1:0]    eff_radix;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff;
   logic                  rsp_last_ff;
   logic [RADIX_W-1:0]    rd_data_ff;
   logic [RADIX_W-1:0]    digit_mem [MAX_DIGITS];
   logic                  req_xfer;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_value;
   logic [VALUE_BITS-1:0] quotient;
   div_status_type        div_status;
   logic                  room;
   logic                  mem_wr;
   logic [CNT_W-1:0]      count_next;

   // CSR port
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == REG_RADIX) ? DATA_W'(radix_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_RADIX) begin
         radix_ff <= csr_pwdata[RADIX_W-1:0];
      end
   end

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && (state_ff == ST_IDLE);

   assign room       = (count_ff < CNT_W'(MAX_DIGITS));
   assign mem_wr     = (state_ff == ST_DIV) && div_status.done && room;
   assign count_next = room ? count_ff + 1'b1 : count_ff;

   assign div_start = req_xfer ||
                      ((state_ff == ST_DIV) && div_status.done && !div_status.quot_zero);
   assign div_value = (state_ff == ST_IDLE) ? req_value : quotient;

   rac_digit_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .radix    (eff_radix),
      .value    (div_value),
      .status   (div_status),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               count_in = count_next;
               if (div_status.quot_zero) begin
                  idx_in   = IDX_W'(count_next - 1'b1);
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_LD;
         end
         ST_LD: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (state_ff == ST_LD) begin
         rsp_char_ff <= to_ascii(rd_data_ff);
         rsp_last_ff <= (idx_ff == '0);
      end
   end

   // digit memory, least significant digit at entry 0
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         digit_mem[count_ff[IDX_W-1:0]] <= div_status.digit;
      end
      if (state_ff == ST_RD) begin
         rd_data_ff <= digit_mem[idx_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule
